/* sv/vnan_pkg.sv */
package vnan_pkg;

    localparam int unsigned IDX_W = 12;
    localparam int unsigned VEC_W = 16;
    localparam int unsigned SUM_W = 32;
    localparam int unsigned CNT_W = 13;
    localparam int unsigned SQ_W  = 64;
    localparam int unsigned LEN_W = 32;
    localparam int unsigned QT_W  = 16;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ACC   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_RD,
        S_RD_NORM,
        S_RD_WAIT
    } t_top_state;

    typedef enum logic [3:0] {
        N_IDLE,
        N_MUL,
        N_ACC,
        N_CHK,
        N_SHIFT,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } t_norm_state;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
    } t_norm_req;

    typedef struct packed {
        logic                    done;
        logic signed [VEC_W-1:0] ux;
        logic signed [VEC_W-1:0] uy;
        logic signed [VEC_W-1:0] uz;
    } t_norm_rsp;

endpackage

/* sv/vertex_normal_accumulate_normalize.sv */
// Channel   | Direction | Signals                                          | Handshake
// ----------+-----------+--------------------------------------------------+---------------------
// command   | in        | i_command, i_vertex_index, i_normal_index, i_load_* | start && !busy
// result    | out       | o_out_vertex, o_unit_x/y/z, o_range_error        | o_strobe, 1 cycle
// config    | in        | i_cfg_data (vertex_count)                        | i_cfg_valid && o_cfg_ready
//
// Busy: a load or a flagged request never raises busy, and a flagged
// result comes on the next cycle. An accumulate holds busy through read and write.
// A read holds busy through fetch, squaring, 0 to 30 normalize shifts, 31 or 32
// square-root steps and three divisions in the normalizer; a zero sum skips the
// shifts, root and divisions. The result comes in the cycle busy drops.
// Reset and the clear request sweep the sum memory one vertex per cycle,
// with busy high for the whole sweep. The result port has no back-pressure.
module vertex_normal_accumulate_normalize #(
    parameter int unsigned MAX_VERTICES = 4096,
    parameter int unsigned MAX_NORMALS  = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_command,
    input  logic [vnan_pkg::IDX_W-1:0]         i_vertex_index,
    input  logic [vnan_pkg::IDX_W-1:0]         i_normal_index,
    input  logic signed [vnan_pkg::VEC_W-1:0]  i_load_x,
    input  logic signed [vnan_pkg::VEC_W-1:0]  i_load_y,
    input  logic signed [vnan_pkg::VEC_W-1:0]  i_load_z,
    output logic                               o_strobe,
    output logic [vnan_pkg::IDX_W-1:0]         o_out_vertex,
    output logic signed [vnan_pkg::VEC_W-1:0]  o_unit_x,
    output logic signed [vnan_pkg::VEC_W-1:0]  o_unit_y,
    output logic signed [vnan_pkg::VEC_W-1:0]  o_unit_z,
    output logic                               o_range_error,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vnan_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam int unsigned VAW = $clog2(MAX_VERTICES);
    localparam int unsigned NAW = $clog2(MAX_NORMALS);
    localparam int unsigned VW  = vnan_pkg::VEC_W;
    localparam int unsigned SW  = vnan_pkg::SUM_W;
    localparam int unsigned IW  = vnan_pkg::IDX_W;

    // Saturating add of a Q2.14 component into a Q18.14 sum.
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                              input logic [VW-1:0] b);
        logic [SW:0] s;
        s = {a[SW-1], a} + {{(SW-VW+1){b[VW-1]}}, b};
        if (s[SW] != s[SW-1]) begin
            sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_add = s[SW-1:0];
        end
    endfunction

    vnan_pkg::t_top_state r_state, n_state;

    logic [vnan_pkg::CNT_W-1:0] r_vcount;
    logic [IW-1:0]              r_vidx, n_vidx;
    logic [IW-1:0]              r_nidx, n_nidx;
    logic [VAW-1:0]             r_clr_addr, n_clr_addr;

    logic                       r_strobe, n_strobe;
    logic [IW-1:0]              r_out_vertex, n_out_vertex;
    logic [VW-1:0]              r_ux, n_ux, r_uy, n_uy, r_uz, n_uz;
    logic                       r_err, n_err;

    logic                       accept;
    vnan_pkg::t_cmd             cmd;
    logic                       v_ok, n_ok;

    logic                       nrm_we, nrm_re;
    logic [3*VW-1:0]            nrm_rdata;
    logic                       sum_we, sum_re;
    logic [VAW-1:0]             sum_waddr;
    logic [3*SW-1:0]            sum_wdata, sum_rdata;

    vnan_pkg::t_norm_req        norm_req;
    vnan_pkg::t_norm_rsp        norm_rsp;

    assign busy        = (r_state != vnan_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign cmd         = vnan_pkg::t_cmd'(i_command);
    assign o_cfg_ready = 1'b1;

    // Index in range when below both the register and the table depth.
    assign v_ok = ({1'b0, i_vertex_index} < r_vcount)
               && (32'(i_vertex_index) < 32'(MAX_VERTICES));
    assign n_ok = (32'(i_normal_index) < 32'(MAX_NORMALS));

    // Loads go straight into the normal table on the accepting edge.
    assign nrm_we = accept && (cmd == vnan_pkg::CMD_LOAD) && n_ok;
    assign nrm_re = (r_state == vnan_pkg::S_ACC_RD);

    vnan_ram #(
        .WIDTH(3*VW),
        .DEPTH(MAX_NORMALS)
    ) u_nrm_ram (
        .i_clk  (i_clk),
        .i_we   (nrm_we),
        .i_waddr(NAW'(i_normal_index)),
        .i_wdata({i_load_x, i_load_y, i_load_z}),
        .i_re   (nrm_re),
        .i_raddr(NAW'(r_nidx)),
        .o_rdata(nrm_rdata)
    );

    // Sum memory: x in the top third, z in the bottom.
    assign sum_re    = (r_state == vnan_pkg::S_ACC_RD) || (r_state == vnan_pkg::S_RD_RD);
    assign sum_we    = (r_state == vnan_pkg::S_CLEAR) || (r_state == vnan_pkg::S_ACC_WR);
    assign sum_waddr = (r_state == vnan_pkg::S_CLEAR) ? r_clr_addr : VAW'(r_vidx);
    assign sum_wdata = (r_state == vnan_pkg::S_CLEAR) ? '0 :
                       {sat_add(sum_rdata[3*SW-1:2*SW], nrm_rdata[3*VW-1:2*VW]),
                        sat_add(sum_rdata[2*SW-1:SW],   nrm_rdata[2*VW-1:VW]),
                        sat_add(sum_rdata[SW-1:0],      nrm_rdata[VW-1:0])};

    vnan_ram #(
        .WIDTH(3*SW),
        .DEPTH(MAX_VERTICES)
    ) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (sum_we),
        .i_waddr(sum_waddr),
        .i_wdata(sum_wdata),
        .i_re   (sum_re),
        .i_raddr(VAW'(r_vidx)),
        .o_rdata(sum_rdata)
    );

    assign norm_req.start = (r_state == vnan_pkg::S_RD_NORM);
    assign norm_req.sx    = sum_rdata[3*SW-1:2*SW];
    assign norm_req.sy    = sum_rdata[2*SW-1:SW];
    assign norm_req.sz    = sum_rdata[SW-1:0];

    vnan_norm u_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (norm_req),
        .o_rsp  (norm_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= vnan_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_vcount   <= vnan_pkg::CNT_W'(4096);
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_strobe   <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
        r_vidx       <= n_vidx;
        r_nidx       <= n_nidx;
        r_out_vertex <= n_out_vertex;
        r_ux         <= n_ux;
        r_uy         <= n_uy;
        r_uz         <= n_uz;
        r_err        <= n_err;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_vidx       = r_vidx;
        n_nidx       = r_nidx;
        n_strobe     = 1'b0;
        n_out_vertex = r_out_vertex;
        n_ux         = r_ux;
        n_uy         = r_uy;
        n_uz         = r_uz;
        n_err        = r_err;

        unique case (r_state)
            vnan_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == VAW'(MAX_VERTICES - 1)) begin
                    n_clr_addr = '0;
                    n_state    = vnan_pkg::S_IDLE;
                end
            end
            vnan_pkg::S_IDLE: begin
                if (accept) begin
                    n_vidx = i_vertex_index;
                    n_nidx = i_normal_index;
                    unique case (cmd)
                        vnan_pkg::CMD_LOAD: begin
                            if (!n_ok) begin
                                n_strobe     = 1'b1;
                                n_out_vertex = i_vertex_index;
                                n_ux         = '0;
                                n_uy         = '0;
                                n_uz         = '0;
                                n_err        = 1'b1;
                            end
                        end
                        vnan_pkg::CMD_ACC: begin
                            if (v_ok && n_ok) begin
                                n_state = vnan_pkg::S_ACC_RD;
                            end else begin
                                n_strobe     = 1'b1;
                                n_out_vertex = i_vertex_index;
                                n_ux         = '0;
                                n_uy         = '0;
                                n_uz         = '0;
                                n_err        = 1'b1;
                            end
                        end
                        vnan_pkg::CMD_READ: begin
                            if (v_ok) begin
                                n_state = vnan_pkg::S_RD_RD;
                            end else begin
                                n_strobe     = 1'b1;
                                n_out_vertex = i_vertex_index;
                                n_ux         = '0;
                                n_uy         = '0;
                                n_uz         = '0;
                                n_err        = 1'b1;
                            end
                        end
                        vnan_pkg::CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = vnan_pkg::S_CLEAR;
                        end
                        default: begin
                            n_state = vnan_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            vnan_pkg::S_ACC_RD: begin
                n_state = vnan_pkg::S_ACC_WR;
            end
            vnan_pkg::S_ACC_WR: begin
                n_state = vnan_pkg::S_IDLE;
            end
            vnan_pkg::S_RD_RD: begin
                n_state = vnan_pkg::S_RD_NORM;
            end
            vnan_pkg::S_RD_NORM: begin
                n_state = vnan_pkg::S_RD_WAIT;
            end
            vnan_pkg::S_RD_WAIT: begin
                if (norm_rsp.done) begin
                    n_strobe     = 1'b1;
                    n_out_vertex = r_vidx;
                    n_ux         = norm_rsp.ux;
                    n_uy         = norm_rsp.uy;
                    n_uz         = norm_rsp.uz;
                    n_err        = 1'b0;
                    n_state      = vnan_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vnan_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_out_vertex  = r_out_vertex;
    assign o_unit_x      = r_ux;
    assign o_unit_y      = r_uy;
    assign o_unit_z      = r_uz;
    assign o_range_error = r_err;

endmodule

/* sv/vnan_ram.sv */
module vnan_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

/* sv/vnan_norm.sv */
// Sequential vector normalizer: shared multiplier for the squares, then
// 2-bit normalize shifts, bit-pair square root, and restoring division.
module vnan_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vnan_pkg::t_norm_req i_req,
    output vnan_pkg::t_norm_rsp o_rsp
);

    localparam int unsigned SW = vnan_pkg::SUM_W;
    localparam int unsigned QW = vnan_pkg::SQ_W;
    localparam int unsigned LW = vnan_pkg::LEN_W;
    localparam int unsigned TW = vnan_pkg::QT_W;
    localparam int unsigned VW = vnan_pkg::VEC_W;

    vnan_pkg::t_norm_state r_state, n_state;

    logic [SW-1:0]  r_mag [3];
    logic [SW-1:0]  n_mag [3];
    logic [2:0]     r_neg, n_neg;
    logic [1:0]     r_j, n_j;
    logic [QW-1:0]  r_prod, n_prod;
    logic [QW-1:0]  r_q, n_q;
    logic [4:0]     r_k, n_k;
    logic [QW-1:0]  r_res, n_res;
    logic [5:0]     r_bpos, n_bpos;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_rem, n_rem;
    logic [TW-1:0]  r_nlo, n_nlo;
    logic [TW-1:0]  r_quot, n_quot;
    logic [3:0]     r_cnt, n_cnt;
    logic [VW-1:0]  r_u [3];
    logic [VW-1:0]  n_u [3];

    logic [QW-1:0]  bitv;
    logic [QW-1:0]  trial;
    logic [SW-1:0]  shv;
    logic [46:0]    num;
    logic [LW:0]    sh;
    logic           qbit;
    logic [TW-1:0]  qfin;
    logic [TW-1:0]  qclamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vnan_pkg::N_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_j    <= n_j;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_k    <= n_k;
        r_res  <= n_res;
        r_bpos <= n_bpos;
        r_len  <= n_len;
        r_rem  <= n_rem;
        r_nlo  <= n_nlo;
        r_quot <= n_quot;
        r_cnt  <= n_cnt;
        r_u    <= n_u;
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_j     = r_j;
        n_prod  = r_prod;
        n_q     = r_q;
        n_k     = r_k;
        n_res   = r_res;
        n_bpos  = r_bpos;
        n_len   = r_len;
        n_rem   = r_rem;
        n_nlo   = r_nlo;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_u     = r_u;

        bitv   = QW'(1) << r_bpos;
        trial  = r_res + bitv;
        shv    = r_mag[r_j] << r_k;
        num    = {shv, 14'd0} + 47'(r_len >> 1);
        sh     = {r_rem, r_nlo[TW-1]};
        qbit   = (sh >= {1'b0, r_len});
        qfin   = {r_quot[TW-2:0], qbit};
        qclamp = qfin[TW-1] ? {1'b0, {(TW-1){1'b1}}} : qfin;

        unique case (r_state)
            vnan_pkg::N_IDLE: begin
                if (i_req.start) begin
                    n_neg = {i_req.sz[SW-1], i_req.sy[SW-1], i_req.sx[SW-1]};
                    n_mag[0] = i_req.sx[SW-1] ? (~i_req.sx + 1'b1) : i_req.sx;
                    n_mag[1] = i_req.sy[SW-1] ? (~i_req.sy + 1'b1) : i_req.sy;
                    n_mag[2] = i_req.sz[SW-1] ? (~i_req.sz + 1'b1) : i_req.sz;
                    n_q      = '0;
                    n_j      = '0;
                    n_state  = vnan_pkg::N_MUL;
                end
            end
            vnan_pkg::N_MUL: begin
                n_prod  = r_mag[r_j] * r_mag[r_j];
                n_state = vnan_pkg::N_ACC;
            end
            vnan_pkg::N_ACC: begin
                n_q = r_q + r_prod;
                if (r_j == 2'd2) begin
                    n_state = vnan_pkg::N_CHK;
                end else begin
                    n_j     = r_j + 2'd1;
                    n_state = vnan_pkg::N_MUL;
                end
            end
            vnan_pkg::N_CHK: begin
                if (r_q == '0) begin
                    n_u[0]  = '0;
                    n_u[1]  = '0;
                    n_u[2]  = '0;
                    n_state = vnan_pkg::N_DONE;
                end else begin
                    n_k     = '0;
                    n_state = vnan_pkg::N_SHIFT;
                end
            end
            vnan_pkg::N_SHIFT: begin
                if (r_q[QW-1:QW-4] == '0) begin
                    n_q = r_q << 2;
                    n_k = r_k + 5'd1;
                end else begin
                    n_res   = '0;
                    n_bpos  = (r_q[QW-1:QW-2] != '0) ? 6'd62 : 6'd60;
                    n_state = vnan_pkg::N_SQRT;
                end
            end
            vnan_pkg::N_SQRT: begin
                if (r_q >= trial) begin
                    n_q   = r_q - trial;
                    n_res = (r_res >> 1) + bitv;
                end else begin
                    n_res = r_res >> 1;
                end
                if (r_bpos == '0) begin
                    n_len   = n_res[LW-1:0];
                    n_j     = '0;
                    n_state = vnan_pkg::N_DLOAD;
                end else begin
                    n_bpos = r_bpos - 6'd2;
                end
            end
            vnan_pkg::N_DLOAD: begin
                // num < len * 2^16, so the top part starts below len
                n_rem   = 32'(num[46:TW]);
                n_nlo   = num[TW-1:0];
                n_quot  = '0;
                n_cnt   = '0;
                n_state = vnan_pkg::N_DIV;
            end
            vnan_pkg::N_DIV: begin
                n_rem  = qbit ? LW'(sh - {1'b0, r_len}) : sh[LW-1:0];
                n_quot = qfin;
                n_nlo  = r_nlo << 1;
                n_cnt  = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_u[r_j] = r_neg[r_j] ? (~qclamp + 1'b1) : qclamp;
                    if (r_j == 2'd2) begin
                        n_state = vnan_pkg::N_DONE;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = vnan_pkg::N_DLOAD;
                    end
                end
            end
            vnan_pkg::N_DONE: begin
                n_state = vnan_pkg::N_IDLE;
            end
            default: begin
                n_state = vnan_pkg::N_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_state == vnan_pkg::N_DONE);
    assign o_rsp.ux   = r_u[0];
    assign o_rsp.uy   = r_u[1];
    assign o_rsp.uz   = r_u[2];

endmodule

/* tb/vertex_normal_accumulate_normalize_test.sv */
`timescale 1ns / 1ps

module vertex_normal_accumulate_normalize_test;

    localparam int unsigned IDX_W     = vnan_pkg::IDX_W;
    localparam int unsigned VEC_W     = vnan_pkg::VEC_W;
    localparam int unsigned SUM_W     = vnan_pkg::SUM_W;
    localparam int unsigned CNT_W     = vnan_pkg::CNT_W;

    localparam int unsigned NVERT     = 4096;
    localparam int unsigned NNORM     = 4096;
    // a clear sweep holds busy high across all NVERT vertices
    localparam int unsigned SETTLE    = 200;
    localparam int unsigned TAIL      = NVERT + 400;
    localparam int unsigned WDOG_MAX  = 4 * NVERT + 4000;
    localparam int unsigned PHASES    = 5;
    localparam int unsigned PHASE_LEN = 300;

    // what the driver does with one queue entry
    typedef enum logic [1:0] {
        STEP_REQ,    // one request on the command port
        STEP_CFG,    // vertex_count write, once all results are in
        STEP_DRAIN   // hold off until every result has come
    } t_step;

    typedef struct {
        t_step             kind;
        vnan_pkg::t_cmd    cmd;
        logic [IDX_W-1:0]  vtx;
        logic [IDX_W-1:0]  nrm;
        logic [VEC_W-1:0]  lx;
        logic [VEC_W-1:0]  ly;
        logic [VEC_W-1:0]  lz;
        logic [CNT_W-1:0]  count;
        bit                gaps_ok;
    } t_step_item;

    typedef struct {
        logic [IDX_W-1:0]  vtx;
        logic [VEC_W-1:0]  ux;
        logic [VEC_W-1:0]  uy;
        logic [VEC_W-1:0]  uz;
        logic              rerr;
    } t_unit_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_command = '0;
    logic [IDX_W-1:0]          i_vertex_index = '0;
    logic [IDX_W-1:0]          i_normal_index = '0;
    logic signed [VEC_W-1:0]   i_load_x = '0;
    logic signed [VEC_W-1:0]   i_load_y = '0;
    logic signed [VEC_W-1:0]   i_load_z = '0;
    logic                      o_strobe;
    logic [IDX_W-1:0]          o_out_vertex;
    logic signed [VEC_W-1:0]   o_unit_x;
    logic signed [VEC_W-1:0]   o_unit_y;
    logic signed [VEC_W-1:0]   o_unit_z;
    logic                      o_range_error;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CNT_W-1:0]          i_cfg_data = '0;

    vertex_normal_accumulate_normalize #(
        .MAX_VERTICES (NVERT),
        .MAX_NORMALS  (NNORM)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_normal_index (i_normal_index),
        .i_load_x       (i_load_x),
        .i_load_y       (i_load_y),
        .i_load_z       (i_load_z),
        .o_strobe       (o_strobe),
        .o_out_vertex   (o_out_vertex),
        .o_unit_x       (o_unit_x),
        .o_unit_y       (o_unit_y),
        .o_unit_z       (o_unit_z),
        .o_range_error  (o_range_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow of the block's state, advanced at each accepted request.
    logic signed [VEC_W-1:0]  src_x [NNORM];
    logic signed [VEC_W-1:0]  src_y [NNORM];
    logic signed [VEC_W-1:0]  src_z [NNORM];
    logic signed [SUM_W-1:0]  acc_x [NVERT];
    logic signed [SUM_W-1:0]  acc_y [NVERT];
    logic signed [SUM_W-1:0]  acc_z [NVERT];
    logic [CNT_W-1:0]         vertex_limit = CNT_W'(NVERT);

    t_step_item    pending_steps [$];
    t_unit_result  expected_units [$];
    bit            failed = 1'b0;

    function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] a,
                                                        logic signed [VEC_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (s < -64'sh8000_0000) return 32'sh8000_0000;
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [63:0] magnitude(logic signed [SUM_W-1:0] s);
        return s < 0 ? 64'(-longint'(s)) : 64'(longint'(s));
    endfunction

    // bitwise integer square root, two bits of radicand per step
    function automatic logic [63:0] int_sqrt(logic [63:0] q);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > q) bitpos >>= 2;
        while (bitpos != 0) begin
            if (q >= root + bitpos) begin
                q -= root + bitpos;
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    // Q18.14 sum component -> Q2.14 unit component, rounded to nearest
    function automatic logic [VEC_W-1:0] unit_component(logic signed [SUM_W-1:0] s,
                                                        int k, logic [63:0] len);
        logic [63:0] num;
        logic [63:0] r;
        num = (magnitude(s) << k) << 14;
        r = (num + (len >> 1)) / len;
        if (r > 64'd32767) r = 64'd32767;
        return s < 0 ? VEC_W'(-r) : VEC_W'(r);
    endfunction

    task automatic predict_request(input t_step_item it);
        t_unit_result res;
        logic [63:0]  q;
        logic [63:0]  len;
        int           k;
        bit           vtx_ok;
        vtx_ok = 13'(it.vtx) < vertex_limit;   // normal index always fits
        res = '{vtx: it.vtx, ux: '0, uy: '0, uz: '0, rerr: 1'b1};
        case (it.cmd)
            vnan_pkg::CMD_LOAD: begin
                src_x[it.nrm] = it.lx;
                src_y[it.nrm] = it.ly;
                src_z[it.nrm] = it.lz;
            end
            vnan_pkg::CMD_ACC: begin
                if (vtx_ok) begin
                    acc_x[it.vtx] = sat_sum(acc_x[it.vtx], src_x[it.nrm]);
                    acc_y[it.vtx] = sat_sum(acc_y[it.vtx], src_y[it.nrm]);
                    acc_z[it.vtx] = sat_sum(acc_z[it.vtx], src_z[it.nrm]);
                end else begin
                    expected_units.insert(expected_units.size(), res);
                end
            end
            vnan_pkg::CMD_READ: begin
                if (vtx_ok) begin
                    res.rerr = 1'b0;
                    q = magnitude(acc_x[it.vtx]) * magnitude(acc_x[it.vtx])
                      + magnitude(acc_y[it.vtx]) * magnitude(acc_y[it.vtx])
                      + magnitude(acc_z[it.vtx]) * magnitude(acc_z[it.vtx]);
                    if (q != 0) begin
                        // normalize up to bit 60 before the root
                        k = 0;
                        while ((q >> 60) == 0) begin
                            q <<= 2;
                            k++;
                        end
                        len = int_sqrt(q);
                        res.ux = unit_component(acc_x[it.vtx], k, len);
                        res.uy = unit_component(acc_y[it.vtx], k, len);
                        res.uz = unit_component(acc_z[it.vtx], k, len);
                    end
                end
                expected_units.insert(expected_units.size(), res);
            end
            default: begin
                for (int v = 0; v < NVERT; v++) begin
                    acc_x[v] = '0;
                    acc_y[v] = '0;
                    acc_z[v] = '0;
                end
            end
        endcase
    endtask

    // Driver: one request or config write in flight at a time, strobes held
    // until the handshake; each port signal gets one assignment per edge.
    bit  req_live = 1'b0;
    bit  cfg_live = 1'b0;
    int  gap_left = 0;
    int  settle_cnt = 0;

    always @(posedge i_clk) begin
        t_step_item head;
        if (i_rst_n) begin
            if (req_live && !busy) begin
                predict_request(pending_steps.pop_front());
                req_live = 1'b0;
            end
            if (cfg_live && o_cfg_ready) begin
                head = pending_steps.pop_front();
                vertex_limit = head.count;
                cfg_live = 1'b0;
            end
            if (!req_live && !cfg_live && pending_steps.size() > 0) begin
                head = pending_steps[0];
                if (gap_left > 0) begin
                    gap_left--;
                end else if (head.kind == STEP_REQ) begin
                    if (head.gaps_ok && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 5) - 1;
                    end else begin
                        req_live = 1'b1;
                        i_command <= head.cmd;
                        i_vertex_index <= head.vtx;
                        i_normal_index <= head.nrm;
                        i_load_x <= head.lx;
                        i_load_y <= head.ly;
                        i_load_z <= head.lz;
                    end
                end else if (expected_units.size() != 0 || busy) begin
                    settle_cnt = 0;
                end else if (settle_cnt < SETTLE) begin
                    // accumulates and clears give no result; wait until idle
                    settle_cnt++;
                end else begin
                    settle_cnt = 0;
                    if (head.kind == STEP_CFG) begin
                        cfg_live = 1'b1;
                        i_cfg_data <= head.count;
                    end else begin
                        void'(pending_steps.pop_front());
                    end
                end
            end
        end
        start <= req_live;
        i_cfg_valid <= cfg_live;
    end

    // Monitor: every strobe must match the oldest expected result.
    always @(posedge i_clk) begin
        t_unit_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_units.size() == 0) begin
                $error("unexpected result for vertex %0d", o_out_vertex);
                failed = 1'b1;
            end else begin
                want = expected_units.pop_front();
                if (o_out_vertex !== want.vtx) begin
                    $error("out_vertex: expected %0d, got %0d", want.vtx, o_out_vertex);
                    failed = 1'b1;
                end
                if (o_unit_x !== want.ux) begin
                    $error("unit_x: expected %0d, got %0d",
                           $signed(want.ux), o_unit_x);
                    failed = 1'b1;
                end
                if (o_unit_y !== want.uy) begin
                    $error("unit_y: expected %0d, got %0d",
                           $signed(want.uy), o_unit_y);
                    failed = 1'b1;
                end
                if (o_unit_z !== want.uz) begin
                    $error("unit_z: expected %0d, got %0d",
                           $signed(want.uz), o_unit_z);
                    failed = 1'b1;
                end
                if (o_range_error !== want.rerr) begin
                    $error("range_error: expected %0d, got %0d",
                           want.rerr, o_range_error);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: cycles with no request, config write or result accepted.
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus generation; tracks which normal entries were loaded so that an
    // accumulate never reads an unwritten entry.
    bit  gen_loaded [NNORM];
    int  loaded_ids [$];

    task automatic add_req(input vnan_pkg::t_cmd cmd, input int vtx, input int nrm,
                           input int lx, input int ly, input int lz, input bit gaps);
        t_step_item it;
        it = '{kind: STEP_REQ, cmd: cmd, vtx: IDX_W'(vtx), nrm: IDX_W'(nrm),
               lx: VEC_W'(lx), ly: VEC_W'(ly), lz: VEC_W'(lz), count: '0, gaps_ok: gaps};
        pending_steps.insert(pending_steps.size(), it);
        if (cmd == vnan_pkg::CMD_LOAD && !gen_loaded[nrm]) begin
            gen_loaded[nrm] = 1'b1;
            loaded_ids.insert(loaded_ids.size(), nrm);
        end
    endtask

    task automatic add_ctl(input t_step kind, input int count);
        t_step_item it;
        it = '{kind: kind, cmd: vnan_pkg::CMD_LOAD, vtx: '0, nrm: '0, lx: '0, ly: '0,
               lz: '0, count: CNT_W'(count), gaps_ok: 1'b0};
        pending_steps.insert(pending_steps.size(), it);
    endtask

    initial begin
        int  pick;
        int  vtx;
        int  lim;
        bit  gaps;
        vnan_pkg::t_cmd cmd;

        // sums start at zero, as after the reset sweep
        for (int v = 0; v < NVERT; v++) begin
            acc_x[v] = '0;
            acc_y[v] = '0;
            acc_z[v] = '0;
        end

        // directed: field extremes, zero sum, tiny sum, repeated corners, clear,
        // zero and small vertex counts
        add_ctl(STEP_CFG, NVERT);
        add_req(vnan_pkg::CMD_LOAD, 0, 0, 32767, -32768, 0, 1'b1);
        add_req(vnan_pkg::CMD_LOAD, 0, 4095, -32768, -32768, -32768, 1'b1);
        add_req(vnan_pkg::CMD_LOAD, 0, 2, 0, 0, 1, 1'b1);
        add_req(vnan_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_ACC, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_ACC, 4095, 4095, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 4095, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_ACC, 5, 2, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 5, 0, 0, 0, 0, 1'b1);
        // the same corner several times on one vertex, back to back
        for (int i = 0; i < 4; i++) add_req(vnan_pkg::CMD_ACC, 7, 0, 0, 0, 0, 1'b0);
        add_req(vnan_pkg::CMD_READ, 7, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 7, 0, 0, 0, 0, 1'b1);
        add_ctl(STEP_CFG, 0);
        add_req(vnan_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_ACC, 0, 0, 0, 0, 0, 1'b1);
        add_ctl(STEP_CFG, 1);
        add_req(vnan_pkg::CMD_ACC, 0, 2, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_READ, 1, 0, 0, 0, 0, 1'b1);
        add_req(vnan_pkg::CMD_ACC, 1, 0, 0, 0, 0, 1'b1);

        // random phases, each behind a full drain and a new vertex count
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: lim = 16;
                1: lim = 8191;
                2: lim = $urandom_range(1, 4096);
                3: lim = 5000;
                default: lim = NVERT;
            endcase
            add_ctl(STEP_DRAIN, 0);
            add_ctl(STEP_CFG, lim);
            gaps = (p < PHASES - 1);   // last phase runs at full rate
            for (int i = 0; i < PHASE_LEN; i++) begin
                pick = $urandom_range(0, 199);
                if (pick < 2) cmd = vnan_pkg::CMD_CLEAR;
                else if (pick < 45) cmd = vnan_pkg::CMD_LOAD;
                else if (pick < 140) cmd = vnan_pkg::CMD_ACC;
                else cmd = vnan_pkg::CMD_READ;
                if (cmd == vnan_pkg::CMD_ACC && loaded_ids.size() == 0)
                    cmd = vnan_pkg::CMD_LOAD;
                pick = $urandom_range(0, 9);
                if (pick < 7) vtx = $urandom_range(0, 15);
                else if (pick < 9) vtx = $urandom_range(0, 4095);
                else vtx = (lim > 4096) ? 4095 : lim - 1 + $urandom_range(0, 1);
                if (cmd == vnan_pkg::CMD_LOAD)
                    add_req(cmd, vtx,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 31),
                            $urandom, $urandom, $urandom, gaps);
                else
                    add_req(cmd, vtx,
                            (cmd == vnan_pkg::CMD_ACC)
                                ? loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]
                                : $urandom_range(0, 4095),
                            $urandom, $urandom, $urandom, gaps);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_steps.size() != 0 || expected_units.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (!failed && expected_units.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
